/* hw/rtl/wfc_pkg.sv */
// ----------------------------------------------------------------------------
// wfc_pkg
// Shared types, constants and tables for the waypoint follow controller.
// ----------------------------------------------------------------------------
package wfc_pkg;

  localparam int DEF_MAX_WAYPOINTS = 64;

  // Fixed-point constants (angles in rad * 65536 unless noted)
  localparam int CORDIC_STEPS = 17;
  localparam int PI_Q16       = 205887;
  localparam int TWO_PI_Q16   = 411775;
  localparam int HALF_PI_Q13  = 12868;
  localparam int CORDIC_K_Q16 = 39797;

  // Datapath widths
  localparam int CW = 44;  // CORDIC x/y
  localparam int ZW = 24;  // CORDIC angle
  localparam int LW = 11;  // route length compare

  // Register reset values
  localparam logic [30:0] RST_TOL   = 31'd32768;
  localparam logic [15:0] RST_HGAIN = 16'd256;
  localparam logic [15:0] RST_SGAIN = 16'd256;
  localparam logic [14:0] RST_LLIM  = 15'd256;
  localparam logic [14:0] RST_ALIM  = 15'd256;
  localparam logic [14:0] RST_THR   = 15'd6434;
  localparam logic [6:0]  RST_RLEN  = 7'd1;

  typedef enum logic [1:0] {
    KIND_POSE  = 2'd0,
    KIND_LOAD  = 2'd1,
    KIND_START = 2'd2,
    KIND_STOP  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_TOL   = 3'd0,
    REG_HGAIN = 3'd1,
    REG_SGAIN = 3'd2,
    REG_LLIM  = 3'd3,
    REG_ALIM  = 3'd4,
    REG_THR   = 3'd5,
    REG_RLEN  = 3'd6
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE, S_READ, S_SQX, S_SQY, S_SUM, S_SQRT, S_CMP, S_NORM, S_VEC,
    S_ERR, S_MTURN, S_TURN, S_FWD, S_ROT, S_MCOS, S_COS, S_EMIT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_DIFF, OP_SQX, OP_SQY, OP_SUM, OP_SQRT, OP_CHECK,
    OP_NORM, OP_VEC, OP_ERR, OP_MTURN, OP_TURN, OP_FWD, OP_ROT, OP_MCOS,
    OP_COS, OP_EMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic need_calc;
    logic out_free;
    logic sqrt_last;
    logic arrive;
    logic norm_done;
    logic cordic_last;
    logic fwd_skip;
  } sts_t;

  // atan(2^-i) in rad * 65536
  function automatic logic [15:0] atan_q16(input logic [4:0] i);
    logic [15:0] v;
    case (i)
      5'd0:    v = 16'd51472;
      5'd1:    v = 16'd30385;
      5'd2:    v = 16'd16055;
      5'd3:    v = 16'd8150;
      5'd4:    v = 16'd4091;
      5'd5:    v = 16'd2047;
      5'd6:    v = 16'd1024;
      5'd7:    v = 16'd512;
      5'd8:    v = 16'd256;
      5'd9:    v = 16'd128;
      5'd10:   v = 16'd64;
      5'd11:   v = 16'd32;
      5'd12:   v = 16'd16;
      5'd13:   v = 16'd8;
      5'd14:   v = 16'd4;
      5'd15:   v = 16'd2;
      5'd16:   v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/wfc_in_if.sv */
// ----------------------------------------------------------------------------
// wfc_in_if
// Input item channel: valid/ready handshake with command and pose payload.
// ----------------------------------------------------------------------------
interface wfc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic signed [15:0] pose_yaw;
  logic               pose_valid;
  logic [5:0]         load_slot;
  logic signed [31:0] load_x;
  logic signed [31:0] load_y;

  modport source (output valid, kind, pose_x, pose_y, pose_yaw, pose_valid,
                  load_slot, load_x, load_y, input ready);
  modport sink   (input valid, kind, pose_x, pose_y, pose_yaw, pose_valid,
                  load_slot, load_x, load_y, output ready);
endinterface

/* hw/rtl/wfc_out_if.sv */
// ----------------------------------------------------------------------------
// wfc_out_if
// Result item channel: valid/ready handshake with status and commands.
// ----------------------------------------------------------------------------
interface wfc_out_if;
  logic               valid;
  logic               ready;
  logic               running;
  logic               finished;
  logic [5:0]         target_slot;
  logic [31:0]        range_to_target;
  logic [14:0]        forward_cmd;
  logic signed [15:0] turn_cmd;

  modport source (output valid, running, finished, target_slot, range_to_target,
                  forward_cmd, turn_cmd, input ready);
  modport sink   (input valid, running, finished, target_slot, range_to_target,
                  forward_cmd, turn_cmd, output ready);
endinterface

/* hw/rtl/wfc_ram.sv */
// ----------------------------------------------------------------------------
// wfc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wfc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/wfc_ctrl.sv */
// ----------------------------------------------------------------------------
// wfc_ctrl
// Sequencer: walks the datapath through distance, heading and speed steps.
// ----------------------------------------------------------------------------
module wfc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  wfc_pkg::sts_t sts,
  output wfc_pkg::cmd_t cmd
);

  wfc_pkg::state_t state_r, state_nxt;
  logic            fire;

  // a pose that needs computing only needs the result register at the end
  assign in_ready = (state_r == wfc_pkg::S_IDLE) && (sts.out_free || sts.need_calc);
  assign fire     = in_valid && in_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wfc_pkg::S_IDLE:  if (fire && sts.need_calc) state_nxt = wfc_pkg::S_READ;
      wfc_pkg::S_READ:  state_nxt = wfc_pkg::S_SQX;
      wfc_pkg::S_SQX:   state_nxt = wfc_pkg::S_SQY;
      wfc_pkg::S_SQY:   state_nxt = wfc_pkg::S_SUM;
      wfc_pkg::S_SUM:   state_nxt = wfc_pkg::S_SQRT;
      wfc_pkg::S_SQRT:  if (sts.sqrt_last) state_nxt = wfc_pkg::S_CMP;
      wfc_pkg::S_CMP:   state_nxt = sts.arrive ? wfc_pkg::S_EMIT : wfc_pkg::S_NORM;
      wfc_pkg::S_NORM:  if (sts.norm_done) state_nxt = wfc_pkg::S_VEC;
      wfc_pkg::S_VEC:   if (sts.cordic_last) state_nxt = wfc_pkg::S_ERR;
      wfc_pkg::S_ERR:   state_nxt = wfc_pkg::S_MTURN;
      wfc_pkg::S_MTURN: state_nxt = wfc_pkg::S_TURN;
      wfc_pkg::S_TURN:  state_nxt = wfc_pkg::S_FWD;
      wfc_pkg::S_FWD:   state_nxt = sts.fwd_skip ? wfc_pkg::S_EMIT : wfc_pkg::S_ROT;
      wfc_pkg::S_ROT:   if (sts.cordic_last) state_nxt = wfc_pkg::S_MCOS;
      wfc_pkg::S_MCOS:  state_nxt = wfc_pkg::S_COS;
      wfc_pkg::S_COS:   state_nxt = wfc_pkg::S_EMIT;
      wfc_pkg::S_EMIT:  if (sts.out_free) state_nxt = wfc_pkg::S_IDLE;
      default:          state_nxt = wfc_pkg::S_IDLE;
    endcase
  end

  // datapath command per state
  always_comb begin
    cmd.op = wfc_pkg::OP_NONE;
    case (state_r)
      wfc_pkg::S_IDLE:  if (fire) cmd.op = wfc_pkg::OP_ACCEPT;
      wfc_pkg::S_READ:  cmd.op = wfc_pkg::OP_DIFF;
      wfc_pkg::S_SQX:   cmd.op = wfc_pkg::OP_SQX;
      wfc_pkg::S_SQY:   cmd.op = wfc_pkg::OP_SQY;
      wfc_pkg::S_SUM:   cmd.op = wfc_pkg::OP_SUM;
      wfc_pkg::S_SQRT:  cmd.op = wfc_pkg::OP_SQRT;
      wfc_pkg::S_CMP:   cmd.op = wfc_pkg::OP_CHECK;
      wfc_pkg::S_NORM:  cmd.op = wfc_pkg::OP_NORM;
      wfc_pkg::S_VEC:   cmd.op = wfc_pkg::OP_VEC;
      wfc_pkg::S_ERR:   cmd.op = wfc_pkg::OP_ERR;
      wfc_pkg::S_MTURN: cmd.op = wfc_pkg::OP_MTURN;
      wfc_pkg::S_TURN:  cmd.op = wfc_pkg::OP_TURN;
      wfc_pkg::S_FWD:   cmd.op = wfc_pkg::OP_FWD;
      wfc_pkg::S_ROT:   cmd.op = wfc_pkg::OP_ROT;
      wfc_pkg::S_MCOS:  cmd.op = wfc_pkg::OP_MCOS;
      wfc_pkg::S_COS:   cmd.op = wfc_pkg::OP_COS;
      wfc_pkg::S_EMIT:  if (sts.out_free) cmd.op = wfc_pkg::OP_EMIT;
      default:          cmd.op = wfc_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wfc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hw/rtl/wfc_dp.sv */
// ----------------------------------------------------------------------------
// wfc_dp
// Datapath: config registers, route state, waypoint RAM, shared multiplier,
// bit-serial square root, shared CORDIC and the result register.
// ----------------------------------------------------------------------------
module wfc_dp #(
  parameter int MAX_WAYPOINTS = wfc_pkg::DEF_MAX_WAYPOINTS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic [1:0]         in_kind,
  input  logic signed [31:0] in_pose_x,
  input  logic signed [31:0] in_pose_y,
  input  logic signed [15:0] in_pose_yaw,
  input  logic               in_pose_valid,
  input  logic [5:0]         in_load_slot,
  input  logic signed [31:0] in_load_x,
  input  logic signed [31:0] in_load_y,
  input  wfc_pkg::cmd_t      cmd,
  output wfc_pkg::sts_t      sts,
  wfc_out_if.source          out_ch
);

  localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
  localparam int CW = wfc_pkg::CW;
  localparam int ZW = wfc_pkg::ZW;
  localparam int LW = wfc_pkg::LW;

  // configuration
  logic [30:0] tol_r;
  logic [15:0] hgain_r, sgain_r;
  logic [14:0] llim_r, alim_r, thr_r;
  logic [6:0]  rlen_r;

  // route state
  logic       active_r, active_nxt;
  logic       done_r, done_nxt;
  logic [5:0] slot_r, slot_nxt;

  // work registers
  logic signed [31:0]   px_r, px_nxt, py_r, py_nxt;
  logic signed [15:0]   yaw_r, yaw_nxt;
  logic signed [32:0]   dx_r, dx_nxt, dy_r, dy_nxt;
  logic signed [65:0]   prod_r, prod_nxt;
  logic [63:0]          acc_r, acc_nxt;
  logic [65:0]          rad_r, rad_nxt;
  logic [35:0]          rem_r, rem_nxt;
  logic [32:0]          root_r, root_nxt;
  logic [5:0]           cnt_r, cnt_nxt;
  logic signed [CW-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [ZW-1:0] cz_r, cz_nxt;
  logic signed [17:0]   err_r, err_nxt;
  logic signed [15:0]   turn_r, turn_nxt;
  logic [14:0]          fwd_r, fwd_nxt;
  logic [31:0]          range_r, range_nxt;

  // result register
  logic               ov_r, ov_nxt;
  logic               orun_r, orun_nxt, ofin_r, ofin_nxt;
  logic [5:0]         oslot_r, oslot_nxt;
  logic [31:0]        orange_r, orange_nxt;
  logic [14:0]        ofwd_r, ofwd_nxt;
  logic signed [15:0] oturn_r, oturn_nxt;

  // RAM
  logic          ram_we;
  logic [63:0]   ram_rdata;
  logic signed [31:0] wx, wy;

  // combinational helpers
  logic [32:0]          ax, ay;
  logic signed [32:0]   mul_a, mul_b;
  logic [35:0]          rem_sh, trial;
  logic [31:0]          dist_w;
  logic [CW-1:0]        mag_m;
  logic signed [CW-1:0] xs, ys;
  logic signed [ZW-1:0] ang;
  logic                 rot_neg;
  logic signed [ZW-1:0] zq;
  logic signed [24:0]   e;
  logic signed [24:0]   e_p4;
  logic signed [65:0]   tq, fq, alim_s;
  logic [17:0]          err_mag;
  logic [16:0]          cos_c;
  logic [LW-1:0]        len, slot_p1;
  logic                 last_wp;
  logic                 load_ok;

  assign wx = $signed(ram_rdata[63:32]);
  assign wy = $signed(ram_rdata[31:0]);
  assign load_ok = int'(in_load_slot) < MAX_WAYPOINTS;
  assign ram_we = (cmd.op == wfc_pkg::OP_ACCEPT) &&
                  (wfc_pkg::kind_t'(in_kind) == wfc_pkg::KIND_LOAD) && load_ok;

  wfc_ram #(.WIDTH(64), .DEPTH(MAX_WAYPOINTS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_load_slot)),
    .wdata ({in_load_x, in_load_y}),
    .raddr (AW'(slot_r)),
    .rdata (ram_rdata)
  );

  // magnitudes and distance
  assign ax     = dx_r[32] ? 33'(-dx_r) : 33'(dx_r);
  assign ay     = dy_r[32] ? 33'(-dy_r) : 33'(dy_r);
  assign dist_w = root_r[32] ? 32'hFFFF_FFFF : root_r[31:0];

  // one square-root digit
  assign rem_sh = {rem_r[33:0], rad_r[65:64]};
  assign trial  = {1'b0, root_r, 2'b01};

  // CORDIC step helpers
  assign mag_m   = (cx_r > cy_r) ? cx_r : cy_r;
  assign xs      = cx_r >>> cnt_r[4:0];
  assign ys      = cy_r >>> cnt_r[4:0];
  assign ang     = $signed({8'd0, wfc_pkg::atan_q16(cnt_r[4:0])});
  assign rot_neg = (cmd.op == wfc_pkg::OP_VEC) ? (cy_r > 0) : (cz_r < 0);

  // heading error from vector angle
  always_comb begin
    zq = cz_r;
    if (dx_r[32]) zq = ZW'(wfc_pkg::PI_Q16) - zq;
    if (dy_r[32]) zq = -zq;
    e = 25'(zq) - $signed({{6{yaw_r[15]}}, yaw_r, 3'b000});
    if (e > 25'(wfc_pkg::PI_Q16)) e = e - 25'(wfc_pkg::TWO_PI_Q16);
    if (e < -25'(wfc_pkg::PI_Q16)) e = e + 25'(wfc_pkg::TWO_PI_Q16);
    e_p4 = e + 25'sd4;
  end

  // command rounding
  assign tq     = (prod_r + 66'sd4096) >>> 13;
  assign fq     = (prod_r + 66'sd32768) >>> 16;
  assign alim_s = $signed({51'd0, alim_r});
  assign err_mag = err_r[17] ? 18'(-err_r) : 18'(err_r);
  assign cos_c  = (cx_r < 0) ? 17'd0 :
                  (cx_r > CW'(65536)) ? 17'd65536 : cx_r[16:0];

  // route length, clamped
  always_comb begin
    len = LW'(rlen_r);
    if (len > LW'(MAX_WAYPOINTS)) len = LW'(MAX_WAYPOINTS);
    if (len == '0) len = LW'(1);
    slot_p1 = LW'(slot_r) + LW'(1);
    last_wp = slot_p1 >= len;
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      wfc_pkg::OP_SQX: begin
        mul_a = $signed(ax);
        mul_b = $signed(ax);
      end
      wfc_pkg::OP_SQY: begin
        mul_a = $signed(ay);
        mul_b = $signed(ay);
      end
      wfc_pkg::OP_MTURN: begin
        mul_a = $signed({17'd0, hgain_r});
        mul_b = $signed({{15{err_r[17]}}, err_r});
      end
      wfc_pkg::OP_TURN: begin
        mul_a = $signed({17'd0, sgain_r});
        mul_b = $signed({1'b0, range_r});
      end
      wfc_pkg::OP_MCOS: begin
        mul_a = $signed({18'd0, fwd_r});
        mul_b = $signed({16'd0, cos_c});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // status to the sequencer
  always_comb begin
    sts.need_calc   = (wfc_pkg::kind_t'(in_kind) == wfc_pkg::KIND_POSE) &&
                      in_pose_valid && active_r && !done_r;
    sts.out_free    = !ov_r || out_ch.ready;
    sts.sqrt_last   = cnt_r == 6'd32;
    sts.arrive      = {1'b0, tol_r} >= dist_w;
    sts.norm_done   = (mag_m[CW-1:40] != '0) || (mag_m == '0);
    sts.cordic_last = cnt_r == 6'(wfc_pkg::CORDIC_STEPS - 1);
    sts.fwd_skip    = (err_mag > 18'(thr_r)) || (err_mag > 18'(wfc_pkg::HALF_PI_Q13));
  end

  // datapath operations
  always_comb begin
    active_nxt = active_r;
    done_nxt   = done_r;
    slot_nxt   = slot_r;
    px_nxt = px_r; py_nxt = py_r; yaw_nxt = yaw_r;
    dx_nxt = dx_r; dy_nxt = dy_r;
    prod_nxt = prod_r; acc_nxt = acc_r;
    rad_nxt = rad_r; rem_nxt = rem_r; root_nxt = root_r; cnt_nxt = cnt_r;
    cx_nxt = cx_r; cy_nxt = cy_r; cz_nxt = cz_r;
    err_nxt = err_r; turn_nxt = turn_r; fwd_nxt = fwd_r; range_nxt = range_r;
    ov_nxt = ov_r && !out_ch.ready;
    orun_nxt = orun_r; ofin_nxt = ofin_r; oslot_nxt = oslot_r;
    orange_nxt = orange_r; ofwd_nxt = ofwd_r; oturn_nxt = oturn_r;

    case (cmd.op)
      wfc_pkg::OP_ACCEPT: begin
        case (wfc_pkg::kind_t'(in_kind))
          wfc_pkg::KIND_START: begin
            active_nxt = 1'b1;
            done_nxt   = 1'b0;
            slot_nxt   = '0;
          end
          wfc_pkg::KIND_STOP: active_nxt = 1'b0;
          wfc_pkg::KIND_POSE: begin
            px_nxt  = in_pose_x;
            py_nxt  = in_pose_y;
            yaw_nxt = in_pose_yaw;
            // nothing to compute: report status with zero commands
            if (!sts.need_calc) begin
              ov_nxt     = 1'b1;
              orun_nxt   = active_r;
              ofin_nxt   = done_r;
              oslot_nxt  = slot_r;
              orange_nxt = '0;
              ofwd_nxt   = '0;
              oturn_nxt  = '0;
            end
          end
          default: ;
        endcase
      end
      wfc_pkg::OP_DIFF: begin
        dx_nxt = $signed({wx[31], wx}) - $signed({px_r[31], px_r});
        dy_nxt = $signed({wy[31], wy}) - $signed({py_r[31], py_r});
      end
      wfc_pkg::OP_SQX: prod_nxt = mul_a * mul_b;
      wfc_pkg::OP_SQY: begin
        prod_nxt = mul_a * mul_b;
        acc_nxt  = prod_r[63:0];
      end
      wfc_pkg::OP_SUM: begin
        rad_nxt  = {2'b00, acc_r} + {2'b00, prod_r[63:0]};
        rem_nxt  = '0;
        root_nxt = '0;
        cnt_nxt  = '0;
      end
      wfc_pkg::OP_SQRT: begin
        if (rem_sh >= trial) begin
          rem_nxt  = rem_sh - trial;
          root_nxt = {root_r[31:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh;
          root_nxt = {root_r[31:0], 1'b0};
        end
        rad_nxt = {rad_r[63:0], 2'b00};
        cnt_nxt = cnt_r + 6'd1;
      end
      wfc_pkg::OP_CHECK: begin
        fwd_nxt  = '0;
        turn_nxt = '0;
        if (sts.arrive) begin
          if (last_wp) begin
            done_nxt   = 1'b1;
            active_nxt = 1'b0;
            range_nxt  = dist_w;
          end else begin
            slot_nxt  = slot_r + 6'd1;
            range_nxt = '0;
          end
        end else begin
          range_nxt = dist_w;
          cx_nxt    = $signed(CW'(ax));
          cy_nxt    = $signed(CW'(ay));
        end
      end
      wfc_pkg::OP_NORM: begin
        // scale up until the larger component reaches 2^40
        if (!sts.norm_done) begin
          if (mag_m[CW-1:36] == '0) begin
            cx_nxt = cx_r <<< 4;
            cy_nxt = cy_r <<< 4;
          end else begin
            cx_nxt = cx_r <<< 1;
            cy_nxt = cy_r <<< 1;
          end
        end
        cz_nxt  = '0;
        cnt_nxt = '0;
      end
      wfc_pkg::OP_VEC, wfc_pkg::OP_ROT: begin
        if (rot_neg) begin
          cx_nxt = cx_r + ys;
          cy_nxt = cy_r - xs;
          cz_nxt = cz_r + ang;
        end else begin
          cx_nxt = cx_r - ys;
          cy_nxt = cy_r + xs;
          cz_nxt = cz_r - ang;
        end
        cnt_nxt = cnt_r + 6'd1;
      end
      wfc_pkg::OP_ERR: err_nxt = 18'(e_p4 >>> 3);
      wfc_pkg::OP_MTURN: prod_nxt = mul_a * mul_b;
      wfc_pkg::OP_TURN: begin
        if (tq > alim_s)       turn_nxt = $signed({1'b0, alim_r});
        else if (tq < -alim_s) turn_nxt = -$signed({1'b0, alim_r});
        else                   turn_nxt = tq[15:0];
        prod_nxt = mul_a * mul_b;
      end
      wfc_pkg::OP_FWD: begin
        if (sts.fwd_skip)                 fwd_nxt = '0;
        else if (fq > $signed({51'd0, llim_r})) fwd_nxt = llim_r;
        else                              fwd_nxt = fq[14:0];
        // set up cos(err) rotation
        cx_nxt  = CW'(wfc_pkg::CORDIC_K_Q16);
        cy_nxt  = '0;
        cz_nxt  = $signed({{3{err_r[17]}}, err_r, 3'b000});
        cnt_nxt = '0;
      end
      wfc_pkg::OP_MCOS: prod_nxt = mul_a * mul_b;
      wfc_pkg::OP_COS:  fwd_nxt = fq[14:0];
      wfc_pkg::OP_EMIT: begin
        ov_nxt     = 1'b1;
        orun_nxt   = active_r;
        ofin_nxt   = done_r;
        oslot_nxt  = slot_r;
        orange_nxt = range_r;
        ofwd_nxt   = fwd_r;
        oturn_nxt  = turn_r;
      end
      default: ;
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      slot_r   <= '0;
      ov_r     <= 1'b0;
      tol_r    <= wfc_pkg::RST_TOL;
      hgain_r  <= wfc_pkg::RST_HGAIN;
      sgain_r  <= wfc_pkg::RST_SGAIN;
      llim_r   <= wfc_pkg::RST_LLIM;
      alim_r   <= wfc_pkg::RST_ALIM;
      thr_r    <= wfc_pkg::RST_THR;
      rlen_r   <= wfc_pkg::RST_RLEN;
    end else begin
      active_r <= active_nxt;
      done_r   <= done_nxt;
      slot_r   <= slot_nxt;
      ov_r     <= ov_nxt;
      if (cfg_we) begin
        case (wfc_pkg::reg_idx_t'(cfg_index))
          wfc_pkg::REG_TOL:   tol_r   <= cfg_data;
          wfc_pkg::REG_HGAIN: hgain_r <= cfg_data[15:0];
          wfc_pkg::REG_SGAIN: sgain_r <= cfg_data[15:0];
          wfc_pkg::REG_LLIM:  llim_r  <= cfg_data[14:0];
          wfc_pkg::REG_ALIM:  alim_r  <= cfg_data[14:0];
          wfc_pkg::REG_THR:   thr_r   <= cfg_data[14:0];
          wfc_pkg::REG_RLEN:  rlen_r  <= cfg_data[6:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    px_r <= px_nxt; py_r <= py_nxt; yaw_r <= yaw_nxt;
    dx_r <= dx_nxt; dy_r <= dy_nxt;
    prod_r <= prod_nxt; acc_r <= acc_nxt;
    rad_r <= rad_nxt; rem_r <= rem_nxt; root_r <= root_nxt; cnt_r <= cnt_nxt;
    cx_r <= cx_nxt; cy_r <= cy_nxt; cz_r <= cz_nxt;
    err_r <= err_nxt; turn_r <= turn_nxt; fwd_r <= fwd_nxt; range_r <= range_nxt;
    orun_r <= orun_nxt; ofin_r <= ofin_nxt; oslot_r <= oslot_nxt;
    orange_r <= orange_nxt; ofwd_r <= ofwd_nxt; oturn_r <= oturn_nxt;
  end

  assign out_ch.valid           = ov_r;
  assign out_ch.running         = orun_r;
  assign out_ch.finished        = ofin_r;
  assign out_ch.target_slot     = oslot_r;
  assign out_ch.range_to_target = orange_r;
  assign out_ch.forward_cmd     = ofwd_r;
  assign out_ch.turn_cmd        = oturn_r;

endmodule

/* hw/rtl/waypoint_follow_controller.sv */
// ----------------------------------------------------------------------------
// waypoint_follow_controller
// Proportional waypoint follower with a loaded route table.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries items: load waypoint, start route, stop, or pose estimate.
//   Load, start and stop give no result.
//   A pose item gives one result on out_ch. If the route is idle, finished or
//   the pose is flagged unusable, the result is ready the cycle after accept.
//   Otherwise a 33-step square root comes first and an arrival ends right
//   after it; else normalize shifts and two 17-step passes of the shared
//   CORDIC (atan2 for the bearing, cos for speed scaling) follow. A heading
//   error past the turn threshold or past pi/2 skips the cos pass. One item
//   is in work at a time. Results sit in an output register. While one waits,
//   a pose that needs computing is still taken and holds in its last step
//   until out_ch drains; other items wait for the drain. Config registers are
//   written on cfg_we only while no item is in work: the user must keep to
//   this, the block does not enforce it. Reset clears route state and loads
//   default gains and limits. The waypoint table is not cleared: only loaded
//   slots may be followed.
// ----------------------------------------------------------------------------
module waypoint_follow_controller #(
  parameter int MAX_WAYPOINTS = wfc_pkg::DEF_MAX_WAYPOINTS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data,
  wfc_in_if.sink      in_ch,
  wfc_out_if.source   out_ch
);

  wfc_pkg::cmd_t cmd;
  wfc_pkg::sts_t sts;
  logic          ready;

  assign in_ch.ready = ready;

  wfc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wfc_dp #(.MAX_WAYPOINTS(MAX_WAYPOINTS)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_kind       (in_ch.kind),
    .in_pose_x     (in_ch.pose_x),
    .in_pose_y     (in_ch.pose_y),
    .in_pose_yaw   (in_ch.pose_yaw),
    .in_pose_valid (in_ch.pose_valid),
    .in_load_slot  (in_ch.load_slot),
    .in_load_x     (in_ch.load_x),
    .in_load_y     (in_ch.load_y),
    .cmd           (cmd),
    .sts           (sts),
    .out_ch        (out_ch)
  );

  // result register is only overwritten once drained
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == wfc_pkg::OP_EMIT) |-> (!out_ch.valid || out_ch.ready))
    else $error("result written while previous result pending");

  // trivial pose reports on the next cycle
  a_quick_pose: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && ready && (in_ch.kind == wfc_pkg::KIND_POSE) && !sts.need_calc)
    |=> out_ch.valid)
    else $error("trivial pose result missing");

  // never running and finished together
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.running && out_ch.finished))
    else $error("running and finished both set");

  // forward motion only while a route is running
  a_fwd_running: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.forward_cmd != '0)) |-> out_ch.running)
    else $error("forward command while not running");

endmodule
